/* src/fpsw_pkg.sv */
// shared types and constants for the pulse source waveform pipeline
`default_nettype none

package fpsw_pkg;

  localparam int APPROX_STEPS = 16;

  localparam logic [30:0] Q30_ONE     = 31'd1073741824;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [19:0] ARG_LIMIT   = 20'd524288;

  // stage map: front end, series steps (three stages each), squarings, back end
  localparam int HORNER_FIRST = 5;
  localparam int SQ_FIRST     = HORNER_FIRST + 3 * (APPROX_STEPS - 1);
  localparam int SQ_COUNT     = 6;
  localparam int POST_FIRST   = SQ_FIRST + SQ_COUNT;
  localparam int NSTAGE       = POST_FIRST + 4;

  typedef enum logic [1:0] {
    KIND_GAUSS_DERIV = 2'd0,
    KIND_RICKER      = 2'd1,
    KIND_MODULATED   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    REG_PULSE_KIND      = 3'd0,
    REG_CENTER_TIME     = 3'd1,
    REG_WIDTH_SCALE     = 3'd2,
    REG_CARRIER_RATE    = 3'd3,
    REG_PULSE_AMPLITUDE = 3'd4,
    REG_HARD_MODE       = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [31:0] field;
    logic [32:0] dt;
    logic [47:0] amag_raw;
    logic [31:0] ph;
    logic [19:0] amag;
    logic [1:0]  quad;
    logic [30:0] q;
    logic [22:0] x;
    logic [30:0] th;
    logic [30:0] y;
    logic [31:0] th2;
    logic [30:0] er;
    logic [30:0] sr;
    logic [31:0] pe;
    logic [31:0] ps;
    logic [31:0] qe;
    logic [31:0] qs;
    logic [30:0] ss;
    logic        cn;
    logic [23:0] cmag;
    logic [61:0] prod;
    logic        pneg;
    logic [23:0] pm;
    logic        vneg;
    logic [39:0] vm;
    logic [31:0] res;
    logic        sat;
  } ctx_t;

endpackage

`default_nettype wire

/* src/fdtd_pulse_source_waveform.sv */
// gaussian derivative, ricker and modulated gaussian pulse source, pipelined
// an input transfer is registered into stage 0 and moves through every stage into the output register
// throughput: one item per cycle; every stage advances together unless the
// output register and its one-entry skid stage are both full
// rst is synchronous: clears stage valid bits, output and skid, loads register defaults
`default_nettype none

module fdtd_pulse_source_waveform import fpsw_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,   // [31:0] sim_time, [63:32] field_in
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [31:0] field_out
  output logic             m_axis_tuser,   // [0] saturated
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  kind_t       pulse_kind;
  logic [31:0] center_time;
  logic [31:0] width_scale;
  logic [31:0] carrier_rate;
  logic [31:0] pulse_amplitude;
  logic        hard_mode;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_kind      <= KIND_GAUSS_DERIV;
      center_time     <= 32'd0;
      width_scale     <= 32'd65536;
      carrier_rate    <= 32'd0;
      pulse_amplitude <= 32'd65536;
      hard_mode       <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_PULSE_KIND:      pulse_kind      <= kind_t'(cfg_data[1:0]);
        REG_CENTER_TIME:     center_time     <= cfg_data;
        REG_WIDTH_SCALE:     width_scale     <= cfg_data;
        REG_CARRIER_RATE:    carrier_rate    <= cfg_data;
        REG_PULSE_AMPLITUDE: pulse_amplitude <= cfg_data;
        REG_HARD_MODE:       hard_mode       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  ctx_t st  [NSTAGE];
  ctx_t nxt [NSTAGE];
  logic vld [NSTAGE];
  logic en;
  logic exit_v;
  logic ovalid;
  logic skid_full;
  logic [31:0] odata;
  logic        osat;
  logic [31:0] skid_data;
  logic        skid_sat;

  assign en            = !skid_full;
  assign s_axis_tready = en;
  assign exit_v        = en && vld[NSTAGE-1];

  // front end: offset, scaled argument and carrier phase, clamp, squares
  logic [32:0] dmag;
  logic [63:0] amul;
  logic [63:0] phmul;
  logic [39:0] xmul;
  logic [61:0] thmul;
  logic [63:0] th2mul;

  assign dmag   = st[0].dt[32] ? (~st[0].dt + 33'd1) : st[0].dt;
  assign amul   = {31'd0, dmag} * {32'd0, width_scale};
  assign phmul  = {{31{st[0].dt[32]}}, st[0].dt} * {32'd0, carrier_rate};
  assign xmul   = {20'd0, st[2].amag} * {20'd0, st[2].amag};
  assign thmul  = {31'd0, st[2].q} * {31'd0, HALF_PI_Q30};
  assign th2mul = {33'd0, st[3].th} * {33'd0, st[3].th};

  always_comb begin
    nxt[0]       = '0;
    nxt[0].dt    = {s_axis_tdata[31], s_axis_tdata[31:0]} - {center_time[31], center_time};
    nxt[0].field = s_axis_tdata[63:32];

    nxt[1]          = st[0];
    nxt[1].amag_raw = amul[63:16];
    nxt[1].ph       = phmul[47:16];

    nxt[2]      = st[1];
    nxt[2].amag = (st[1].amag_raw > {28'd0, ARG_LIMIT}) ? ARG_LIMIT : st[1].amag_raw[19:0];
    nxt[2].quad = st[1].ph[31:30];
    // second and fourth quarter run the angle backward
    nxt[2].q    = st[1].ph[30] ? (Q30_ONE - {1'b0, st[1].ph[29:0]}) : {1'b0, st[1].ph[29:0]};

    nxt[3]    = st[2];
    nxt[3].x  = xmul[38:16];
    nxt[3].th = thmul[60:30];

    nxt[4]     = st[3];
    nxt[4].y   = {st[3].x, 8'd0};
    nxt[4].th2 = th2mul[61:30];
    nxt[4].er  = Q30_ONE;
    nxt[4].sr  = Q30_ONE;
  end

  // horner steps of exp and sin series, side by side; each step is
  // multiply, reciprocal multiply, remainder correction
  for (genvar j = 0; j < APPROX_STEPS - 1; j++) begin : g_step
    localparam int          K   = APPROX_STEPS - 1 - j;
    localparam int          IA  = HORNER_FIRST + 3 * j;
    localparam logic [63:0] DE  = 64'(K);
    localparam logic [63:0] DS  = 64'(2 * K * (2 * K + 1));
    localparam logic [32:0] ME  = 33'((64'd1 << 32) / DE);
    localparam logic [32:0] MS  = 33'((64'd1 << 32) / DS);

    logic [63:0] pe_mul;
    logic [63:0] ps_mul;
    logic [64:0] qe_mul;
    logic [64:0] qs_mul;
    logic [41:0] qe_d;
    logic [41:0] qs_d;
    logic [41:0] re;
    logic [41:0] rs;
    logic [31:0] te;
    logic [31:0] ts;

    assign pe_mul = {33'd0, st[IA-1].y} * {33'd0, st[IA-1].er};
    assign ps_mul = {32'd0, st[IA-1].th2} * {33'd0, st[IA-1].sr};
    assign qe_mul = {33'd0, st[IA].pe} * {32'd0, ME};
    assign qs_mul = {33'd0, st[IA].ps} * {32'd0, MS};
    assign qe_d   = {10'd0, st[IA+1].qe} * DE[41:0];
    assign qs_d   = {10'd0, st[IA+1].qs} * DS[41:0];
    assign re     = {10'd0, st[IA+1].pe} - qe_d;
    assign rs     = {10'd0, st[IA+1].ps} - qs_d;
    // the reciprocal estimate is low by at most one
    assign te     = st[IA+1].qe + {31'd0, (re >= DE[41:0])};
    assign ts     = st[IA+1].qs + {31'd0, (rs >= DS[41:0])};

    always_comb begin
      nxt[IA]    = st[IA-1];
      nxt[IA].pe = pe_mul[61:30];
      nxt[IA].ps = ps_mul[61:30];

      nxt[IA+1]    = st[IA];
      nxt[IA+1].qe = qe_mul[63:32];
      nxt[IA+1].qs = qs_mul[63:32];

      nxt[IA+2]    = st[IA+1];
      nxt[IA+2].er = (te > {1'b0, Q30_ONE}) ? 31'd0 : (Q30_ONE - te[30:0]);
      nxt[IA+2].sr = (ts > {1'b0, Q30_ONE}) ? 31'd0 : (Q30_ONE - ts[30:0]);
    end
  end

  // exp(-x) = exp(-x/64) ** 64 by six squarings
  for (genvar m = 0; m < SQ_COUNT; m++) begin : g_sq
    localparam int IS = SQ_FIRST + m;

    logic [63:0] sq_mul;
    logic [63:0] s_mul;
    logic [23:0] x2;

    assign sq_mul = {33'd0, st[IS-1].er} * {33'd0, st[IS-1].er};
    assign s_mul  = {33'd0, st[IS-1].th} * {33'd0, st[IS-1].sr};
    assign x2     = {st[IS-1].x, 1'b0};

    always_comb begin
      nxt[IS]    = st[IS-1];
      nxt[IS].er = sq_mul[60:30];
      if (m == 0) begin
        nxt[IS].ss = s_mul[60:30];
      end
      if (m == 1) begin
        // ricker factor 1 - 2x as sign and magnitude
        nxt[IS].cn   = (x2 > 24'd65536);
        nxt[IS].cmag = (x2 > 24'd65536) ? (x2 - 24'd65536) : (24'd65536 - x2);
      end
    end
  end

  // back end: pulse shape, amplitude, field update and saturation
  logic [30:0] sel_m;
  logic        sel_neg;
  logic [61:0] pmul;
  logic [23:0] pmag;
  logic [31:0] amp_mag;
  logic [55:0] vmul;
  logic [40:0] val;
  logic [41:0] sum;

  localparam int P1 = POST_FIRST;
  localparam int P2 = POST_FIRST + 1;
  localparam int P3 = POST_FIRST + 2;
  localparam int P4 = POST_FIRST + 3;

  always_comb begin
    case (pulse_kind)
      KIND_GAUSS_DERIV: begin
        sel_m   = {11'd0, st[P1-1].amag};
        sel_neg = !st[P1-1].dt[32];
      end
      KIND_RICKER: begin
        sel_m   = {7'd0, st[P1-1].cmag};
        sel_neg = st[P1-1].cn;
      end
      KIND_MODULATED: begin
        sel_m   = st[P1-1].ss;
        sel_neg = st[P1-1].quad[1];
      end
      default: begin
        sel_m   = 31'd0;
        sel_neg = 1'b0;
      end
    endcase
  end

  assign pmul = {31'd0, sel_m} * {31'd0, st[P1-1].er};

  always_comb begin
    case (pulse_kind)
      KIND_GAUSS_DERIV: pmag = {3'd0, st[P2-1].prod[49:30], 1'b0};
      KIND_RICKER:      pmag = st[P2-1].prod[53:30];
      KIND_MODULATED:   pmag = {6'd0, st[P2-1].prod[61:44]};
      default:          pmag = 24'd0;
    endcase
  end

  assign amp_mag = pulse_amplitude[31] ? (~pulse_amplitude + 32'd1) : pulse_amplitude;
  assign vmul    = {24'd0, amp_mag} * {32'd0, st[P3-1].pm};
  assign val     = st[P4-1].vneg ? (41'd0 - {1'b0, st[P4-1].vm}) : {1'b0, st[P4-1].vm};
  assign sum     = hard_mode ? {val[40], val}
                             : ({{10{st[P4-1].field[31]}}, st[P4-1].field} + {val[40], val});

  always_comb begin
    nxt[P1]      = st[P1-1];
    nxt[P1].prod = pmul;
    nxt[P1].pneg = sel_neg;

    nxt[P2]      = st[P1];
    nxt[P2].pm   = pmag;
    nxt[P2].pneg = st[P1].pneg && (pmag != 24'd0);

    nxt[P3]      = st[P2];
    nxt[P3].vm   = vmul[55:16];
    nxt[P3].vneg = st[P2].pneg != pulse_amplitude[31];

    nxt[P4] = st[P3];
    if (!sum[41] && (sum[40:31] != 10'd0)) begin
      nxt[P4].res = 32'h7fffffff;
      nxt[P4].sat = 1'b1;
    end else if (sum[41] && (sum[40:31] != 10'h3ff)) begin
      nxt[P4].res = 32'h80000000;
      nxt[P4].sat = 1'b1;
    end else begin
      nxt[P4].res = sum[31:0];
      nxt[P4].sat = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NSTAGE; i++) begin
        vld[i] <= 1'b0;
      end
    end else if (en) begin
      vld[0] <= s_axis_tvalid;
      for (int i = 1; i < NSTAGE; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NSTAGE; i++) begin
        st[i] <= nxt[i];
      end
    end
  end

  // output register with one-entry skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid    <= 1'b0;
      skid_full <= 1'b0;
    end else if (!ovalid || m_axis_tready) begin
      ovalid    <= skid_full || exit_v;
      skid_full <= 1'b0;
    end else if (exit_v) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!ovalid || m_axis_tready) begin
      if (skid_full) begin
        odata <= skid_data;
        osat  <= skid_sat;
      end else begin
        odata <= st[NSTAGE-1].res;
        osat  <= st[NSTAGE-1].sat;
      end
    end else if (exit_v) begin
      skid_data <= st[NSTAGE-1].res;
      skid_sat  <= st[NSTAGE-1].sat;
    end
  end

  assign m_axis_tvalid = ovalid;
  assign m_axis_tdata  = odata;
  assign m_axis_tuser  = osat;

  a_skid_needs_output: assert property (@(posedge clk) disable iff (rst)
    skid_full |-> m_axis_tvalid)
    else $error("skid stage holds a result while output register is empty");

  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |->
      (m_axis_tdata == 32'h7fffffff || m_axis_tdata == 32'h80000000))
    else $error("saturation flag set on an unclipped value");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> (!m_axis_tvalid && s_axis_tready))
    else $error("pipeline not empty after reset");

endmodule

`default_nettype wire
